/* design/sbfd_pkg.sv */
// Package for the S.BUS frame decoder: beat types, frame constants, FSM states.
// No dependencies; every other design file but sbfd_ram imports it.
`default_nettype none

package sbfd_pkg;

    localparam int FRAME_LEN  = 25;   // bytes in a valid frame
    localparam int COUNT_SAT  = 26;   // byte count saturation value
    localparam int FLAG_POS   = 23;   // position of the flag byte
    localparam int FIRST_DATA = 1;    // first byte holding channel bits
    localparam int NUM_CH     = 16;
    localparam int CH_W       = 11;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = $clog2(FRAME_LEN);
    localparam int CNT_W      = $clog2(COUNT_SAT + 1);
    localparam int IDX_W      = $clog2(NUM_CH);
    localparam int BUF_W      = CH_W - 1 + BYTE_W;   // leftover bits plus one byte
    localparam int NBITS_W    = $clog2(BUF_W + 1);

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic [7:0]  flag_byte;
        logic        link_alive;
        logic        last_channel;
    } t_out_beat;

    // start request from the collector to the unpacker
    typedef struct packed {
        logic             go;
        logic [BYTE_W-1:0] flag_byte;
    } t_frame_go;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* design/sbus_frame_decoder.sv */
// S.BUS frame decoder, top level: byte collector, 25-byte frame store, unpacker.
// Depends on sbfd_pkg, sbfd_collect, sbfd_ram, sbfd_unpack.
//
// Bytes are taken one per cycle while the block is not decoding. A byte beat
// with frame_end set closes the frame; a frame of exactly 25 bytes that opens
// with 0x0F and ends with 0x00 yields sixteen channel beats, any other frame
// yields none. Decoding reads bytes 1..22 through the single read port of the
// frame store (a read state, then a load state, per byte) and extracts each
// 11-bit channel with one shared shifter, so a good frame keeps o_in_stall
// high until its last channel beat is registered, longer if the output stalls.
// The last channel beat may still wait in the output register while the
// next frame's bytes come in.
`default_nettype none

module sbus_frame_decoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire sbfd_pkg::t_in_beat   i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output sbfd_pkg::t_out_beat       o_out_beat
);
    import sbfd_pkg::*;

    logic              accept;
    logic              busy;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rdata;
    t_frame_go         go;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    sbfd_collect u_collect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_beat  (i_in_beat),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_go    (go)
    );

    sbfd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(FRAME_LEN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    sbfd_unpack u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_busy     (busy),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

endmodule

`default_nettype wire

/* design/sbfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/sbfd_collect.sv */
// Byte collector: counts bytes, writes the frame store, checks the frame at its end.
// Depends on sbfd_pkg.
`default_nettype none

module sbfd_collect (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire sbfd_pkg::t_in_beat             i_beat,
    output logic                                o_we,
    output logic [sbfd_pkg::ADDR_W-1:0]         o_waddr,
    output logic [sbfd_pkg::BYTE_W-1:0]         o_wdata,
    output sbfd_pkg::t_frame_go                 o_go
);
    import sbfd_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_start_ok, n_start_ok;
    logic [BYTE_W-1:0] r_flag, n_flag;
    logic              frame_ok;

    always_comb begin
        n_count    = r_count;
        n_start_ok = r_start_ok;
        n_flag     = r_flag;
        if (i_accept) begin
            if (r_count == '0) begin
                n_start_ok = (i_beat.rx_byte == START_BYTE);
            end
            if (r_count == CNT_W'(FLAG_POS)) begin
                n_flag = i_beat.rx_byte;
            end
            if (i_beat.frame_end) begin
                n_count = '0;
            end else if (r_count < CNT_W'(COUNT_SAT)) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // this beat is byte 24 exactly when 24 bytes are already in
    assign frame_ok = i_accept && i_beat.frame_end && (r_count == CNT_W'(FRAME_LEN - 1))
                      && r_start_ok && (i_beat.rx_byte == END_BYTE);

    assign o_we         = i_accept && (r_count < CNT_W'(FRAME_LEN));
    assign o_waddr      = r_count[ADDR_W-1:0];
    assign o_wdata      = i_beat.rx_byte;
    assign o_go.go        = frame_ok;
    assign o_go.flag_byte = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_start_ok <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_start_ok <= n_start_ok;
        end
        r_flag <= n_flag;
    end

endmodule

`default_nettype wire

/* design/sbfd_unpack.sv */
// Channel unpacker: reads bytes 1..22 one at a time into a bit buffer and
// peels off 11-bit channels with one shared shifter. Depends on sbfd_pkg.
`default_nettype none

module sbfd_unpack (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sbfd_pkg::t_frame_go            i_go,
    output logic [sbfd_pkg::ADDR_W-1:0]         o_raddr,
    input  wire logic [sbfd_pkg::BYTE_W-1:0]    i_rdata,
    output logic                                o_busy,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output sbfd_pkg::t_out_beat                 o_out_beat
);
    import sbfd_pkg::*;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [NBITS_W-1:0] r_nbits, n_nbits;
    logic [IDX_W-1:0]   r_ch, n_ch;
    logic [BYTE_W-1:0]  r_flag, n_flag;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;
    logic               out_free;
    logic [BUF_W-1:0]   ins;

    assign out_free = !r_out_valid || !i_out_stall;
    assign ins      = {{(BUF_W - BYTE_W){1'b0}}, i_rdata} << r_nbits;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_buf       = r_buf;
        n_nbits     = r_nbits;
        n_ch        = r_ch;
        n_flag      = r_flag;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_go.go) begin
                    n_addr  = ADDR_W'(FIRST_DATA);
                    n_buf   = '0;
                    n_nbits = '0;
                    n_ch    = '0;
                    n_flag  = i_go.flag_byte;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // RAM registers the byte at r_addr this cycle
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_buf   = r_buf | ins;
                n_nbits = r_nbits + NBITS_W'(BYTE_W);
                n_addr  = r_addr + ADDR_W'(1);
                n_state = (n_nbits >= NBITS_W'(CH_W)) ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.channel_index = r_ch;
                    n_out.channel_value = r_buf[CH_W-1:0];
                    n_out.flag_byte     = r_flag;
                    n_out.link_alive    = (r_flag == '0);
                    n_out.last_channel  = (r_ch == IDX_W'(NUM_CH - 1));
                    n_buf               = r_buf >> CH_W;
                    n_nbits             = r_nbits - NBITS_W'(CH_W);
                    n_ch                = r_ch + IDX_W'(1);
                    if (r_ch == IDX_W'(NUM_CH - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = (n_nbits >= NBITS_W'(CH_W)) ? ST_EMIT : ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_addr  <= n_addr;
        r_buf   <= n_buf;
        r_nbits <= n_nbits;
        r_ch    <= n_ch;
        r_flag  <= n_flag;
        r_out   <= n_out;
    end

    assign o_raddr     = r_addr;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire

/* design/sbfd_checker.sv */
// Port-level checker for the S.BUS frame decoder, bound to the top level.
// Depends on sbfd_pkg.
`default_nettype none

module sbfd_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire sbfd_pkg::t_in_beat   i_in_beat,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire sbfd_pkg::t_out_beat  o_out_beat
);
    import sbfd_pkg::*;

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_beat))
        else $error("input beat changed while stalled");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    a_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.link_alive == (o_out_beat.flag_byte == '0)))
        else $error("link_alive does not match flag byte");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.last_channel ==
                         (o_out_beat.channel_index == IDX_W'(NUM_CH - 1))))
        else $error("last_channel does not match channel index");

    // input stays closed while a non-final channel beat is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.last_channel |-> o_in_stall)
        else $error("input opened before the frame was fully decoded");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_beat  (i_in_beat),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_beat (o_out_beat)
);

`default_nettype wire
